// ===== rtl/tbsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// tbsrm_pkg: shared types and constants for the speed ramp mixer
// Field widths, function codes, register indexes, register reset values and
// the sequencer state type.
// ----------------------------------------------------------------------------
package tbsrm_pkg;

  // Field widths fixed by the item and register formats
  localparam int FUNC_W     = 2;
  localparam int VALUE_W    = 16;
  localparam int LIN_W      = 15;
  localparam int ANG_W      = 16;
  localparam int STEP_W     = 15;
  localparam int MAXLIN_W   = 14;
  localparam int MAXANG_W   = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEERING = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_THROTTLE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_BRAKE    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COAST_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR = 3'd4;

  // Register reset values
  localparam logic [STEP_W-1:0]   ACCEL_STEP_RST  = 15'd164;
  localparam logic [STEP_W-1:0]   COAST_STEP_RST  = 15'd82;
  localparam logic [STEP_W-1:0]   BRAKE_STEP_RST  = 15'd328;
  localparam logic [MAXLIN_W-1:0] MAX_LINEAR_RST  = 14'd1000;
  localparam logic [MAXANG_W-1:0] MAX_ANGULAR_RST = 15'd1000;

  // Tick sequencer states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE        = 11'b000_0000_0001,
    ST_MUL_BRAKE   = 11'b000_0000_0010,
    ST_DECAY       = 11'b000_0000_0100,
    ST_MUL_ACC     = 11'b000_0000_1000,
    ST_RAMP        = 11'b000_0001_0000,
    ST_LAUNCH      = 11'b000_0010_0000,
    ST_MUL_SPD_LIN = 11'b000_0100_0000,
    ST_MUL_LIN     = 11'b000_1000_0000,
    ST_MUL_SPD_ANG = 11'b001_0000_0000,
    ST_MUL_ANG     = 11'b010_0000_0000,
    ST_FINISH      = 11'b100_0000_0000
  } state_t;

endpackage

// ===== rtl/tbsrm_if.sv =====
// ----------------------------------------------------------------------------
// tbsrm_if: valid/ready channels of the speed ramp mixer
// Command channel (function code and setter value) and result channel
// (linear and angular velocity).
// ----------------------------------------------------------------------------
interface tbsrm_req_if;
  logic                                     valid;
  logic                                     ready;
  logic        [tbsrm_pkg::FUNC_W-1:0]      func;
  logic signed [tbsrm_pkg::VALUE_W-1:0]     value;

  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface tbsrm_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [tbsrm_pkg::LIN_W-1:0]       linear_velocity;
  logic signed [tbsrm_pkg::ANG_W-1:0]       angular_velocity;

  modport source (output valid, linear_velocity, angular_velocity, input ready);
  modport sink   (input valid, linear_velocity, angular_velocity, output ready);
endinterface

// ===== rtl/tbsrm_serial_mul.sv =====
// ----------------------------------------------------------------------------
// tbsrm_serial_mul: bit-serial shift-add multiplier
// Retires one multiplier bit per cycle; the product holds until next start.
// ----------------------------------------------------------------------------
module tbsrm_serial_mul #(
  parameter int AW = 30,
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic [CW-1:0] cnt;
  logic [AW-1:0] mcand;
  logic [AW:0]   sum;

  assign busy = (cnt != '0);

  // add the multiplicand into the high half when the low bit is set
  always_comb begin
    if (prod[0]) begin
      sum = {1'b0, prod[AW+BW-1:BW]} + {1'b0, mcand};
    end else begin
      sum = {1'b0, prod[AW+BW-1:BW]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1));
      if (start) begin
        cnt <= CW'(BW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= {{AW{1'b0}}, b};
      mcand <= a;
    end else if (busy) begin
      prod <= {sum, prod[BW-1:1]};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");

endmodule

// ===== rtl/throttle_brake_speed_ramp_mixer.sv =====
// ----------------------------------------------------------------------------
// throttle_brake_speed_ramp_mixer: car-style controls to diff-drive velocities
// Setters store clamped steering, throttle and brake levels; a tick with fresh
// input decays and ramps the speed and emits linear and angular velocity.
// ----------------------------------------------------------------------------
// Setter transaction: taken in ST_IDLE, which stays put. Tick without fresh input: no result.
// Tick with fresh input: six products on one bit-serial multiplier with an NW-bit
// multiplier operand (NW = max(FRAC_BITS+2, 15)), between ST_DECAY, ST_RAMP, ST_LAUNCH
// and ST_FINISH; FINISH waits for a free result register, then result and input ready rise.
// The result register lets the next command in while a result waits.
// Synchronous reset loads register defaults, zeros all levels and the speed.
module throttle_brake_speed_ramp_mixer #(
  parameter int FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  tbsrm_req_if.sink                          req,
  tbsrm_rsp_if.source                        rsp,
  input  logic                               wr_en,
  input  logic [tbsrm_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [tbsrm_pkg::CFG_DATA_W-1:0]   wr_data
);

  localparam int SW   = FRAC_BITS + 2;                     // speed, steer, throttle
  localparam int MAGW = FRAC_BITS + 1;                     // magnitudes, brake
  localparam int EW   = ((SW > 17) ? SW : 17) + 2;         // update arithmetic
  localparam int MW   = FRAC_BITS + 16;                    // multiplicand
  localparam int NW   = (FRAC_BITS + 2 > 15) ? FRAC_BITS + 2 : 15;
  localparam int PW   = MW + NW;

  localparam logic signed [SW-1:0] ONE_S   = SW'(64'd1 << FRAC_BITS);
  localparam logic signed [EW-1:0] ONE_E   = EW'(64'd1 << FRAC_BITS);
  localparam logic        [MAGW-1:0] ONE_M = MAGW'(64'd1 << FRAC_BITS);
  localparam logic        [NW-1:0] TWO_ONE = NW'(64'd2 << FRAC_BITS);

  // configuration
  logic [tbsrm_pkg::STEP_W-1:0]   accel_step;
  logic [tbsrm_pkg::STEP_W-1:0]   coast_step;
  logic [tbsrm_pkg::STEP_W-1:0]   brake_step;
  logic [tbsrm_pkg::MAXLIN_W-1:0] max_linear;
  logic [tbsrm_pkg::MAXANG_W-1:0] max_angular;

  // state
  logic signed [SW-1:0] speed, speed_next;
  logic signed [SW-1:0] steering;
  logic signed [SW-1:0] throttle_level;
  logic [MAGW-1:0]      brake_level;
  logic                 fresh;
  tbsrm_pkg::state_t    state, state_next;
  logic [tbsrm_pkg::LIN_W-1:0] lin_mag;

  // multiplier
  logic          mul_start;
  logic [MW-1:0] mul_a;
  logic [NW-1:0] mul_b;
  logic          mul_busy;
  logic          mul_done;
  logic [PW-1:0] mul_prod;

  // datapath helpers
  logic                 req_fire;
  logic                 is_tick;
  logic [MAGW-1:0]      spd_mag, steer_mag, thr_mag;
  logic signed [EW-1:0] val_e, clamp_sym, clamp_pos;
  logic signed [EW-1:0] sp_e, tgt_e, dec_e, acc_e, dn_e, up_e, sel_e;
  logic                 ramp_en;
  logic                 out_load;
  logic                 lin_neg, ang_neg;
  logic [tbsrm_pkg::ANG_W-1:0] ang_mag;

  assign req.ready = (state == tbsrm_pkg::ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign is_tick   = (req.func == tbsrm_pkg::FUNC_TICK);

  assign spd_mag   = MAGW'(speed[SW-1] ? -speed : speed);
  assign steer_mag = MAGW'(steering[SW-1] ? -steering : steering);
  assign thr_mag   = MAGW'(throttle_level[SW-1] ? -throttle_level : throttle_level);

  // setter clamps
  always_comb begin
    val_e = {{(EW - tbsrm_pkg::VALUE_W){req.value[tbsrm_pkg::VALUE_W-1]}}, req.value};
    if (val_e > ONE_E) begin
      clamp_sym = ONE_E;
    end else if (val_e < -ONE_E) begin
      clamp_sym = -ONE_E;
    end else begin
      clamp_sym = val_e;
    end
    if (val_e > ONE_E) begin
      clamp_pos = ONE_E;
    end else if (val_e < 0) begin
      clamp_pos = '0;
    end else begin
      clamp_pos = val_e;
    end
  end

  // speed decay and ramp
  always_comb begin
    sp_e  = {{(EW-SW){speed[SW-1]}}, speed};
    tgt_e = {{(EW-SW){throttle_level[SW-1]}}, throttle_level};
    acc_e = $signed({{(EW-tbsrm_pkg::STEP_W){1'b0}}, mul_prod[FRAC_BITS +: tbsrm_pkg::STEP_W]});
    dec_e = $signed({{(EW-tbsrm_pkg::STEP_W){1'b0}}, coast_step}) + acc_e;
    dn_e  = '0;
    up_e  = '0;
    sel_e = sp_e;
    ramp_en = (speed < 0 && throttle_level > 0) || (speed > 0 && throttle_level < 0)
              || (spd_mag < thr_mag);
    speed_next = speed;
    if (state == tbsrm_pkg::ST_DECAY) begin
      dn_e = sp_e - dec_e;
      up_e = sp_e + dec_e;
      if (speed > 0) begin
        sel_e = (dn_e < 0) ? '0 : dn_e;
      end else if (speed < 0) begin
        sel_e = (up_e > 0) ? '0 : up_e;
      end
      speed_next = sel_e[SW-1:0];
    end else if (state == tbsrm_pkg::ST_RAMP) begin
      up_e = sp_e + acc_e;
      dn_e = sp_e - acc_e;
      if (ramp_en) begin
        if (sp_e < tgt_e) begin
          sel_e = (up_e > tgt_e) ? tgt_e : up_e;
        end else if (sp_e > tgt_e) begin
          sel_e = (dn_e < tgt_e) ? tgt_e : dn_e;
        end
      end
      speed_next = sel_e[SW-1:0];
    end
  end

  // tick sequencer
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    out_load   = 1'b0;
    unique case (state)
      tbsrm_pkg::ST_IDLE: begin
        if (req_fire && is_tick && fresh) begin
          mul_start  = 1'b1;
          mul_a      = MW'(brake_step);
          mul_b      = NW'(brake_level);
          state_next = tbsrm_pkg::ST_MUL_BRAKE;
        end
      end
      tbsrm_pkg::ST_MUL_BRAKE: begin
        if (mul_done) begin
          state_next = tbsrm_pkg::ST_DECAY;
        end
      end
      tbsrm_pkg::ST_DECAY: begin
        mul_start  = 1'b1;
        mul_a      = MW'(accel_step);
        mul_b      = NW'(thr_mag);
        state_next = tbsrm_pkg::ST_MUL_ACC;
      end
      tbsrm_pkg::ST_MUL_ACC: begin
        if (mul_done) begin
          state_next = tbsrm_pkg::ST_RAMP;
        end
      end
      tbsrm_pkg::ST_RAMP: begin
        state_next = tbsrm_pkg::ST_LAUNCH;
      end
      tbsrm_pkg::ST_LAUNCH: begin
        mul_start  = 1'b1;
        mul_a      = MW'(spd_mag);
        mul_b      = NW'(max_linear);
        state_next = tbsrm_pkg::ST_MUL_SPD_LIN;
      end
      tbsrm_pkg::ST_MUL_SPD_LIN: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = mul_prod[MW-1:0];
          mul_b      = TWO_ONE - NW'(steer_mag);
          state_next = tbsrm_pkg::ST_MUL_LIN;
        end
      end
      tbsrm_pkg::ST_MUL_LIN: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = MW'(spd_mag);
          mul_b      = NW'(max_angular);
          state_next = tbsrm_pkg::ST_MUL_SPD_ANG;
        end
      end
      tbsrm_pkg::ST_MUL_SPD_ANG: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = mul_prod[MW-1:0];
          mul_b      = NW'(steer_mag);
          state_next = tbsrm_pkg::ST_MUL_ANG;
        end
      end
      tbsrm_pkg::ST_MUL_ANG: begin
        if (mul_done) begin
          state_next = tbsrm_pkg::ST_FINISH;
        end
      end
      tbsrm_pkg::ST_FINISH: begin
        // hold until the result register is free
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = tbsrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tbsrm_pkg::ST_IDLE;
      end
    endcase
  end

  tbsrm_serial_mul #(
    .AW (MW),
    .BW (NW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign lin_neg = speed[SW-1];
  assign ang_neg = speed[SW-1] != steering[SW-1];
  assign ang_mag = mul_prod[2*FRAC_BITS +: tbsrm_pkg::ANG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tbsrm_pkg::ST_IDLE;
      speed          <= '0;
      steering       <= '0;
      throttle_level <= '0;
      brake_level    <= '0;
      fresh          <= 1'b0;
      rsp.valid      <= 1'b0;
      accel_step     <= tbsrm_pkg::ACCEL_STEP_RST;
      coast_step     <= tbsrm_pkg::COAST_STEP_RST;
      brake_step     <= tbsrm_pkg::BRAKE_STEP_RST;
      max_linear     <= tbsrm_pkg::MAX_LINEAR_RST;
      max_angular    <= tbsrm_pkg::MAX_ANGULAR_RST;
    end else begin
      state <= state_next;
      speed <= speed_next;
      if (req_fire) begin
        unique case (req.func)
          tbsrm_pkg::FUNC_STEERING: begin
            steering <= clamp_sym[SW-1:0];
            fresh    <= 1'b1;
          end
          tbsrm_pkg::FUNC_THROTTLE: begin
            throttle_level <= clamp_sym[SW-1:0];
            fresh          <= 1'b1;
          end
          tbsrm_pkg::FUNC_BRAKE: begin
            brake_level <= clamp_pos[MAGW-1:0];
            fresh       <= 1'b1;
          end
          tbsrm_pkg::FUNC_TICK: begin
            fresh <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (wr_en) begin
        unique case (wr_index)
          tbsrm_pkg::REG_ACCEL_STEP:  accel_step  <= wr_data;
          tbsrm_pkg::REG_COAST_STEP:  coast_step  <= wr_data;
          tbsrm_pkg::REG_BRAKE_STEP:  brake_step  <= wr_data;
          tbsrm_pkg::REG_MAX_LINEAR:  max_linear  <= wr_data[tbsrm_pkg::MAXLIN_W-1:0];
          tbsrm_pkg::REG_MAX_ANGULAR: max_angular <= wr_data;
          default: begin
          end
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == tbsrm_pkg::ST_MUL_LIN && mul_done) begin
      lin_mag <= mul_prod[2*FRAC_BITS+1 +: tbsrm_pkg::LIN_W];
    end
    if (out_load) begin
      rsp.linear_velocity  <= lin_neg ? $signed(tbsrm_pkg::LIN_W'(0) - lin_mag)
                                      : $signed(lin_mag);
      rsp.angular_velocity <= ang_neg ? $signed(tbsrm_pkg::ANG_W'(0) - ang_mag)
                                      : $signed(ang_mag);
    end
  end

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    speed <= ONE_S && speed >= -ONE_S)
    else $error("speed left the unit range");

  a_brake_range: assert property (@(posedge clk) disable iff (rst)
    brake_level <= ONE_M)
    else $error("brake level above one");

  a_fresh_clear: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.func == tbsrm_pkg::FUNC_TICK) |=> !fresh)
    else $error("fresh mark survived a tick");

  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == tbsrm_pkg::ST_MUL_BRAKE || state == tbsrm_pkg::ST_MUL_ACC
                  || state == tbsrm_pkg::ST_MUL_SPD_LIN || state == tbsrm_pkg::ST_MUL_LIN
                  || state == tbsrm_pkg::ST_MUL_SPD_ANG || state == tbsrm_pkg::ST_MUL_ANG))
    else $error("product finished outside a multiply step");

  a_idle_mul: assert property (@(posedge clk) disable iff (rst)
    (state == tbsrm_pkg::ST_IDLE) |-> !mul_busy)
    else $error("multiplier busy while idle");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the throttle/brake speed ramp mixer
// Drives setter and tick transactions through the command channel, walks
// several register settings from reset values to extremes, and compares
// every velocity result with an in-bench model of speed decay, ramp and
// mixing, or with the typed value of a direct row. Both channels idle at
// random but for the last setting; one long result stall backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int     FRAC        = 14;
  localparam longint ONE         = 64'sd1 << FRAC;
  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam int     SETTLE      = 120;
  localparam int     LONG_HOLD   = 700;
  localparam int     RAND_N      = 218;
  localparam int     N_SETTINGS  = 7;

  localparam logic [tbsrm_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [tbsrm_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic signed [tbsrm_pkg::LIN_W-1:0] lin;
    logic signed [tbsrm_pkg::ANG_W-1:0] ang;
  } vel_t;

  typedef struct {
    logic        [tbsrm_pkg::FUNC_W-1:0]  f;
    logic signed [tbsrm_pkg::VALUE_W-1:0] v;
    bit                                   typed;
    vel_t                                 want;
  } stim_row_t;

  typedef struct packed {
    logic [tbsrm_pkg::STEP_W-1:0]     accel;
    logic [tbsrm_pkg::STEP_W-1:0]     coast;
    logic [tbsrm_pkg::STEP_W-1:0]     brake;
    logic [tbsrm_pkg::CFG_DATA_W-1:0] maxlin;
    logic [tbsrm_pkg::MAXANG_W-1:0]   maxang;
  } cfg_set_t;

  logic clk = 1'b0;
  logic rst;
  logic                             wr_en;
  logic [tbsrm_pkg::CFG_IDX_W-1:0]  wr_index;
  logic [tbsrm_pkg::CFG_DATA_W-1:0] wr_data;

  tbsrm_req_if req_ch ();
  tbsrm_rsp_if rsp_ch ();

  throttle_brake_speed_ramp_mixer #(.FRAC_BITS(FRAC)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #6 clk = ~clk;

  // Model state and register copies
  logic signed [15:0]                speed_lvl, steer_lvl, thr_lvl;
  logic [14:0]                       brk_lvl;
  bit                                fresh;
  logic [tbsrm_pkg::STEP_W-1:0]      p_accel, p_coast, p_brake;
  logic [tbsrm_pkg::MAXLIN_W-1:0]    p_maxlin;
  logic [tbsrm_pkg::MAXANG_W-1:0]    p_maxang;

  vel_t      vel_expected_q[$];
  vel_t      vel_head;
  stim_row_t dir_rows[$];
  cfg_set_t  settings[N_SETTINGS];

  int  err_cnt       = 0;
  int  cycle_cnt     = 0;
  int  cmds_sent     = 0;
  int  items_done    = 0;
  int  results_seen  = 0;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;
  bit  tx_idle_en    = 1'b1;
  bit  rx_idle_en    = 1'b1;
  bit  long_hold_go  = 1'b0;

  task automatic report_mismatch(input string msg);
    if (err_cnt < 100)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic longint clamp_fx(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic longint abs_fx(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Returns 1 when the command yields a velocity result
  function automatic bit mix_predict(input logic [tbsrm_pkg::FUNC_W-1:0] f,
                                     input logic signed [tbsrm_pkg::VALUE_W-1:0] v,
                                     output vel_t res);
    longint raw, spd, dec, acc, tgt, mag, asteer, q;
    bit     neg;
    raw = v;
    res = '0;
    if (f == tbsrm_pkg::FUNC_STEERING) begin
      steer_lvl = 16'(clamp_fx(raw, -ONE, ONE));
      fresh = 1'b1;
      return 1'b0;
    end
    if (f == tbsrm_pkg::FUNC_THROTTLE) begin
      thr_lvl = 16'(clamp_fx(raw, -ONE, ONE));
      fresh = 1'b1;
      return 1'b0;
    end
    if (f == tbsrm_pkg::FUNC_BRAKE) begin
      brk_lvl = 15'(clamp_fx(raw, 0, ONE));
      fresh = 1'b1;
      return 1'b0;
    end
    if (!fresh)
      return 1'b0;
    fresh = 1'b0;

    // decay toward zero, never crossing it
    spd = speed_lvl;
    dec = longint'(p_coast) + ((longint'(p_brake) * longint'(brk_lvl)) >>> FRAC);
    if (spd > 0)
      spd = (spd - dec < 0) ? 0 : spd - dec;
    else if (spd < 0)
      spd = (spd + dec > 0) ? 0 : spd + dec;

    // ramp toward throttle, never overshooting
    tgt = thr_lvl;
    acc = (abs_fx(tgt) * longint'(p_accel)) >>> FRAC;
    if ((spd < 0 && tgt > 0) || (spd > 0 && tgt < 0) || abs_fx(spd) < abs_fx(tgt)) begin
      if (spd < tgt)
        spd = (spd + acc > tgt) ? tgt : spd + acc;
      else if (spd > tgt)
        spd = (spd - acc < tgt) ? tgt : spd - acc;
    end
    speed_lvl = 16'(spd);

    asteer = abs_fx(steer_lvl);
    mag = abs_fx(spd) * longint'(p_maxlin) * (2 * ONE - asteer);
    q = mag >>> (2 * FRAC + 1);
    if (spd < 0) q = -q;
    res.lin = q[tbsrm_pkg::LIN_W-1:0];

    neg = (spd < 0) != (steer_lvl < 0);
    mag = abs_fx(spd) * asteer * longint'(p_maxang);
    q = mag >>> (2 * FRAC);
    if (neg) q = -q;
    res.ang = q[tbsrm_pkg::ANG_W-1:0];
    return 1'b1;
  endfunction

  // Leaves valid high after acceptance; the caller decides what comes next
  task automatic send_cmd(input logic [tbsrm_pkg::FUNC_W-1:0] f,
                          input logic signed [tbsrm_pkg::VALUE_W-1:0] v,
                          input bit typed, input vel_t want);
    vel_t pred;
    bit   counted;
    while (tx_idle_en && $urandom_range(99) < 22) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func  <= f;
    req_ch.value <= v;
    do @(posedge clk); while (!req_ch.ready);
    counted = (f != tbsrm_pkg::FUNC_TICK) || fresh;
    if (mix_predict(f, v, pred))
      vel_expected_q.push_back(typed ? want : pred);
    cmds_sent++;
    if (counted) items_done++;
  endtask

  task automatic add_row(input logic [tbsrm_pkg::FUNC_W-1:0] f,
                         input logic signed [tbsrm_pkg::VALUE_W-1:0] v,
                         input bit typed = 1'b0, input int lin = 0, input int ang = 0);
    stim_row_t r;
    r.f        = f;
    r.v        = v;
    r.typed    = typed;
    r.want.lin = tbsrm_pkg::LIN_W'(lin);
    r.want.ang = tbsrm_pkg::ANG_W'(ang);
    dir_rows.push_back(r);
  endtask

  function automatic logic signed [tbsrm_pkg::VALUE_W-1:0] pick_value(
      input logic [tbsrm_pkg::FUNC_W-1:0] f);
    int r;
    r = $urandom_range(99);
    if (r < 60)
      return tbsrm_pkg::VALUE_W'((f == tbsrm_pkg::FUNC_BRAKE) ? $urandom_range(0, 16384)
                                                              : $urandom_range(0, 32768) - 16384);
    if (r < 75) begin
      case ($urandom_range(6))
        0: return 16'sd16384;
        1: return -16'sd16384;
        2: return 16'sd0;
        3: return 16'sh7FFF;
        4: return 16'sh8000;
        5: return 16'sd1;
        default: return -16'sd1;
      endcase
    end
    return tbsrm_pkg::VALUE_W'($urandom);
  endfunction

  task automatic run_random(input int n);
    int   target, k, r;
    logic [tbsrm_pkg::FUNC_W-1:0] f;
    target = cmds_sent + n;
    while (cmds_sent < target) begin
      r = $urandom_range(99);
      if (r < 75) begin
        // setters with random content, then the tick that consumes them
        k = $urandom_range(0, 3);
        repeat (k) begin
          f = tbsrm_pkg::FUNC_W'(tbsrm_pkg::FUNC_STEERING + $urandom_range(0, 2));
          send_cmd(f, pick_value(f), 1'b0, '0);
        end
        send_cmd(tbsrm_pkg::FUNC_TICK, tbsrm_pkg::VALUE_W'($urandom), 1'b0, '0);
      end else if (r < 90) begin
        send_cmd(tbsrm_pkg::FUNC_TICK, tbsrm_pkg::VALUE_W'($urandom), 1'b0, '0);
      end else begin
        f = tbsrm_pkg::FUNC_W'($urandom_range(0, 3));
        send_cmd(f, tbsrm_pkg::VALUE_W'($urandom), 1'b0, '0);
      end
    end
  endtask

  task automatic quiesce();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (vel_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [tbsrm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tbsrm_pkg::CFG_DATA_W-1:0] d);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= d;
    @(posedge clk);
    case (idx)
      tbsrm_pkg::REG_ACCEL_STEP:  p_accel  = d[tbsrm_pkg::STEP_W-1:0];
      tbsrm_pkg::REG_COAST_STEP:  p_coast  = d[tbsrm_pkg::STEP_W-1:0];
      tbsrm_pkg::REG_BRAKE_STEP:  p_brake  = d[tbsrm_pkg::STEP_W-1:0];
      tbsrm_pkg::REG_MAX_LINEAR:  p_maxlin = d[tbsrm_pkg::MAXLIN_W-1:0];
      tbsrm_pkg::REG_MAX_ANGULAR: p_maxang = d[tbsrm_pkg::MAXANG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input cfg_set_t s);
    cfg_write(tbsrm_pkg::REG_ACCEL_STEP, s.accel);
    cfg_write(tbsrm_pkg::REG_COAST_STEP, s.coast);
    cfg_write(tbsrm_pkg::REG_BRAKE_STEP, s.brake);
    cfg_write(tbsrm_pkg::REG_MAX_LINEAR, s.maxlin);
    cfg_write(tbsrm_pkg::REG_MAX_ANGULAR, s.maxang);
    // writes to unused indexes must not land anywhere
    cfg_write(REG_UNUSED_LO, ~s.accel);
    cfg_write(REG_UNUSED_HI, ~s.maxang);
    wr_en <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (long_hold_go && !hold_done) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= LONG_HOLD;
      hold_done    <= 1'b1;
    end else begin
      rsp_ch.ready <= !rx_idle_en || ($urandom_range(99) >= 22);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (vel_expected_q.size() == 0) begin
        report_mismatch($sformatf("result lin=%0d ang=%0d with nothing expected",
                                  rsp_ch.linear_velocity, rsp_ch.angular_velocity));
      end else begin
        vel_head = vel_expected_q.pop_front();
        if (rsp_ch.linear_velocity !== vel_head.lin)
          report_mismatch($sformatf("result %0d linear_velocity got %0d want %0d",
                                    results_seen, rsp_ch.linear_velocity, vel_head.lin));
        if (rsp_ch.angular_velocity !== vel_head.ang)
          report_mismatch($sformatf("result %0d angular_velocity got %0d want %0d",
                                    results_seen, rsp_ch.angular_velocity, vel_head.ang));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_cnt, vel_expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int p;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.func  <= tbsrm_pkg::FUNC_TICK;
    req_ch.value <= '0;
    wr_en        <= 1'b0;
    wr_index     <= tbsrm_pkg::REG_ACCEL_STEP;
    wr_data      <= '0;

    speed_lvl = '0;
    steer_lvl = '0;
    thr_lvl   = '0;
    brk_lvl   = '0;
    fresh     = 1'b0;
    p_accel   = tbsrm_pkg::ACCEL_STEP_RST;
    p_coast   = tbsrm_pkg::COAST_STEP_RST;
    p_brake   = tbsrm_pkg::BRAKE_STEP_RST;
    p_maxlin  = tbsrm_pkg::MAX_LINEAR_RST;
    p_maxang  = tbsrm_pkg::MAX_ANGULAR_RST;

    // setting 0 is the reset state and is never written
    settings[1] = '{15'd16384, 15'd16384, 15'd16384, 15'd10000, 15'd20000};
    settings[2] = '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
    settings[3] = '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF};
    settings[4] = '{15'd1000, 15'd300, 15'd2000, 15'd5000, 15'd12000};
    settings[5] = '{15'($urandom_range(0, 16384)), 15'($urandom_range(0, 16384)),
                    15'($urandom_range(0, 16384)), 15'($urandom_range(0, 10000)),
                    15'($urandom_range(0, 20000))};
    settings[6] = '{tbsrm_pkg::ACCEL_STEP_RST, tbsrm_pkg::COAST_STEP_RST,
                    tbsrm_pkg::BRAKE_STEP_RST, 15'(tbsrm_pkg::MAX_LINEAR_RST),
                    tbsrm_pkg::MAX_ANGULAR_RST};

    // ticks without fresh input give nothing, clamps hit both ends
    add_row(tbsrm_pkg::FUNC_TICK, 16'sd0);
    add_row(tbsrm_pkg::FUNC_TICK, 16'sh7FFF);
    add_row(tbsrm_pkg::FUNC_STEERING, 16'sd0);
    add_row(tbsrm_pkg::FUNC_TICK, 16'sd0, 1'b1, 0, 0);
    add_row(tbsrm_pkg::FUNC_THROTTLE, 16'sh7FFF);
    add_row(tbsrm_pkg::FUNC_STEERING, 16'sh8000);
    add_row(tbsrm_pkg::FUNC_TICK, 16'sd0);
    add_row(tbsrm_pkg::FUNC_TICK, -16'sd1);
    add_row(tbsrm_pkg::FUNC_BRAKE, -16'sd1);
    add_row(tbsrm_pkg::FUNC_TICK, 16'sh8000);
    add_row(tbsrm_pkg::FUNC_THROTTLE, 16'sh8000);
    add_row(tbsrm_pkg::FUNC_BRAKE, 16'sh7FFF);
    add_row(tbsrm_pkg::FUNC_TICK, 16'sd0);
    add_row(tbsrm_pkg::FUNC_STEERING, 16'sd16384);
    add_row(tbsrm_pkg::FUNC_TICK, 16'sd0);
    add_row(tbsrm_pkg::FUNC_BRAKE, 16'sd8192);
    add_row(tbsrm_pkg::FUNC_THROTTLE, 16'sd16384);
    add_row(tbsrm_pkg::FUNC_STEERING, -16'sd16384);
    add_row(tbsrm_pkg::FUNC_TICK, 16'sd0);
    add_row(tbsrm_pkg::FUNC_THROTTLE, 16'sd0);
    add_row(tbsrm_pkg::FUNC_BRAKE, 16'sd0);
    add_row(tbsrm_pkg::FUNC_TICK, 16'sd0);
    add_row(tbsrm_pkg::FUNC_STEERING, 16'sd1);
    add_row(tbsrm_pkg::FUNC_THROTTLE, -16'sd1);
    add_row(tbsrm_pkg::FUNC_TICK, 16'sd0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].f, dir_rows[i].v, dir_rows[i].typed, dir_rows[i].want);
    run_random(RAND_N);

    for (p = 1; p < N_SETTINGS; p++) begin
      quiesce();
      apply_setting(settings[p]);
      if (p == 4)
        long_hold_go <= 1'b1;
      if (p == N_SETTINGS - 1) begin
        // no idling on either side for the last setting
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
      end
      run_random(RAND_N);
    end
    quiesce();

    $display("Covered %0d commands (%0d effective), %0d velocity results, %0d settings",
             cmds_sent, items_done, results_seen, N_SETTINGS);
    $display("Included clamped setters, idle ticks and a %0d-cycle result stall", LONG_HOLD);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
